FILE: rtl/core/ffrf_pkg.sv
package ffrf_pkg;

   localparam int NUM_SLOTS  = 128;
   localparam int IDX_W      = $clog2(NUM_SLOTS);
   localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
   localparam int SLOT_W     = 7;
   localparam int LEN_W      = 8;
   localparam int START_W    = 7;
   localparam int SLOT_CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int LEN_CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   typedef logic [IDX_W-1:0] addr_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic update;
      logic search_start;
      logic scan_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic search_trivial;
      logic scan_done;
   } status_type;

endpackage

FILE: rtl/core/first_fit_free_run_finder_unit.sv
// Keeps one occupied bit per slot (NUM_SLOTS, 128 by default) and finds the first run of
// empty slots of a requested length, scanning upward from slot 0. After reset the block
// clears the slot map (req_tready low), then all slots are empty.
// An update item (op 0) writes one slot's bit and gives no result; slots at
// or above NUM_SLOTS are ignored. A search item (op 1) reads the map RAM one slot per cycle
// and stops at the first hit or at the last slot; a run length of 0 or above NUM_SLOTS
// skips the scan and answers with found 0. The map RAM has a single read port. Results wait
// in an output register, and the block accepts the next item while one is still pending.
module first_fit_free_run_finder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // slot_index[6:0], occupied[7], run_length[15:8]
   input  logic        req_tuser,  // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // start_index[6:0], zero[7]
   output logic        rsp_tuser   // found[0]
);

   ffrf_pkg::cmd_type    cmd;
   ffrf_pkg::status_type status;
   logic [ffrf_pkg::START_W-1:0] start_index;
   logic                         found;

   ffrf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   ffrf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .slot_index  (req_tdata[6:0]),
      .occupied    (req_tdata[7]),
      .run_length  (req_tdata[15:8]),
      .found       (found),
      .start_index (start_index)
   );

   assign rsp_tdata = {1'b0, start_index};
   assign rsp_tuser = found;

endmodule

FILE: rtl/core/ffrf_ram.sv
module ffrf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/ffrf_datapath.sv
module ffrf_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  ffrf_pkg::cmd_type           cmd,
   output ffrf_pkg::status_type        status,
   input  logic [ffrf_pkg::SLOT_W-1:0] slot_index,
   input  logic                        occupied,
   input  logic [ffrf_pkg::LEN_W-1:0]  run_length,
   output logic                        found,
   output logic [ffrf_pkg::START_W-1:0] start_index
);

   ffrf_pkg::addr_type clr_addr_ff, clr_addr_in;
   ffrf_pkg::addr_type rd_addr_ff, rd_addr_in;
   ffrf_pkg::addr_type pos_ff, pos_in;
   ffrf_pkg::cnt_type  run_ff, run_in;
   ffrf_pkg::cnt_type  base_ff, base_in;
   ffrf_pkg::cnt_type  want_ff, want_in;
   logic                          res_found_ff, res_found_in;
   logic [ffrf_pkg::START_W-1:0]  res_start_ff, res_start_in;
   logic                          found_ff, found_in;
   logic [ffrf_pkg::START_W-1:0]  start_ff, start_in;

   ffrf_pkg::addr_type ram_raddr;
   ffrf_pkg::addr_type ram_waddr;
   logic               ram_we;
   logic               ram_wdata;
   logic               ram_rdata;

   logic               in_range;
   ffrf_pkg::cnt_type  run_plus;
   logic               hit;
   logic               last;

   ffrf_ram #(
      .WIDTH (1),
      .DEPTH (ffrf_pkg::NUM_SLOTS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign in_range = ffrf_pkg::SLOT_CMP_W'(slot_index)
                     < ffrf_pkg::SLOT_CMP_W'(ffrf_pkg::NUM_SLOTS);

   assign ram_we    = cmd.clear_step || (cmd.update && in_range);
   assign ram_waddr = cmd.clear_step ? clr_addr_ff : ffrf_pkg::IDX_W'(slot_index);
   assign ram_wdata = cmd.clear_step ? 1'b0 : occupied;
   assign ram_raddr = cmd.search_start ? '0 : rd_addr_ff;

   assign run_plus = run_ff + ffrf_pkg::CNT_W'(1);
   assign hit      = !ram_rdata && (run_plus == want_ff);
   assign last     = pos_ff == ffrf_pkg::IDX_W'(ffrf_pkg::NUM_SLOTS - 1);

   assign status.clear_last     = clr_addr_ff == ffrf_pkg::IDX_W'(ffrf_pkg::NUM_SLOTS - 1);
   assign status.search_trivial = (run_length == '0)
                                  || (ffrf_pkg::LEN_CMP_W'(run_length)
                                      > ffrf_pkg::LEN_CMP_W'(ffrf_pkg::NUM_SLOTS));
   assign status.scan_done      = hit || last;

   always_comb begin
      clr_addr_in  = clr_addr_ff;
      rd_addr_in   = rd_addr_ff;
      pos_in       = pos_ff;
      run_in       = run_ff;
      base_in      = base_ff;
      want_in      = want_ff;
      res_found_in = res_found_ff;
      res_start_in = res_start_ff;
      found_in     = found_ff;
      start_in     = start_ff;

      if (cmd.clear_step) begin
         clr_addr_in = clr_addr_ff + ffrf_pkg::IDX_W'(1);
      end

      if (cmd.search_start) begin
         rd_addr_in   = ffrf_pkg::IDX_W'(1);
         pos_in       = '0;
         run_in       = '0;
         base_in      = '0;
         want_in      = ffrf_pkg::CNT_W'(run_length);
         res_found_in = 1'b0;
         res_start_in = '0;
      end

      if (cmd.scan_step) begin
         rd_addr_in = rd_addr_ff + ffrf_pkg::IDX_W'(1);
         pos_in     = pos_ff + ffrf_pkg::IDX_W'(1);
         if (ram_rdata) begin
            run_in  = '0;
            base_in = ffrf_pkg::CNT_W'(pos_ff) + ffrf_pkg::CNT_W'(1);
         end else begin
            run_in = run_plus;
         end
         if (hit) begin
            res_found_in = 1'b1;
            res_start_in = ffrf_pkg::START_W'(base_ff);
         end else if (last) begin
            res_found_in = 1'b0;
            res_start_in = '0;
         end
      end

      if (cmd.load_out) begin
         found_in = res_found_ff;
         start_in = res_start_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff   <= rd_addr_in;
      pos_ff       <= pos_in;
      run_ff       <= run_in;
      base_ff      <= base_in;
      want_ff      <= want_in;
      res_found_ff <= res_found_in;
      res_start_ff <= res_start_in;
      found_ff     <= found_in;
      start_ff     <= start_in;
   end

   assign found       = found_ff;
   assign start_index = start_ff;

endmodule

FILE: rtl/core/ffrf_ctrl.sv
module ffrf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 op,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output ffrf_pkg::cmd_type    cmd,
   input  ffrf_pkg::status_type status
);

   ffrf_pkg::state_type state_ff, state_in;
   logic                out_vld_ff, out_vld_in;
   logic                accept;
   logic                out_free;

   assign req_tready = state_ff == ffrf_pkg::ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_vld_ff || rsp_tready;
   assign rsp_tvalid = out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ffrf_pkg::ST_CLEAR;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      cmd        = '0;

      unique case (state_ff)
         ffrf_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ffrf_pkg::ST_IDLE;
            end
         end
         ffrf_pkg::ST_IDLE: begin
            if (accept) begin
               if (op == ffrf_pkg::OP_UPDATE) begin
                  cmd.update = 1'b1;
               end else begin
                  cmd.search_start = 1'b1;
                  state_in = status.search_trivial ? ffrf_pkg::ST_DONE : ffrf_pkg::ST_SCAN;
               end
            end
         end
         ffrf_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = ffrf_pkg::ST_DONE;
            end
         end
         ffrf_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               out_vld_in   = 1'b1;
               state_in     = ffrf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffrf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sim/tb_first_fit_free_run_finder_unit.sv
`timescale 1ns / 100ps

module tb_first_fit_free_run_finder_unit;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 2 * ffrf_pkg::NUM_SLOTS;

   typedef struct packed {
      logic                         found;
      logic [ffrf_pkg::START_W-1:0] start_index;
   } free_run_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;  // slot_index[6:0], occupied[7], run_length[15:8]
   logic        req_tuser = 1'b0;  // op[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;  // start_index[6:0], zero[7]
   logic        rsp_tuser;  // found[0]

   logic [ffrf_pkg::NUM_SLOTS-1:0] slot_map = '0;
   free_run_type                   pending_runs[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int update_count = 0;
   int search_count = 0;
   int found_count = 0;
   int miss_count = 0;
   int quiet_cycles = 0;

   first_fit_free_run_finder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic free_run_type find_first_free_run(int unsigned want);
      free_run_type r;
      int unsigned  run;
      int unsigned  base;
      r = '0;
      run = 0;
      base = 0;
      if (want == 0 || want > ffrf_pkg::NUM_SLOTS) return r;
      for (int i = 0; i < ffrf_pkg::NUM_SLOTS; i++) begin
         if (slot_map[i]) begin
            run = 0;
            base = i + 1;
         end else begin
            run++;
            if (run == want) begin
               r.found = 1'b1;
               r.start_index = ffrf_pkg::START_W'(base);
               return r;
            end
         end
      end
      return r;
   endfunction

   // mostly short runs, some long, some impossible
   function automatic logic [ffrf_pkg::LEN_W-1:0] random_run_length();
      int r;
      r = $urandom_range(99);
      if (r < 50) return ffrf_pkg::LEN_W'($urandom_range(8, 1));
      if (r < 75) return ffrf_pkg::LEN_W'($urandom_range(40, 9));
      if (r < 85) return ffrf_pkg::LEN_W'($urandom_range(ffrf_pkg::NUM_SLOTS, 41));
      if (r < 90) return '0;
      if (r < 95) return ffrf_pkg::LEN_W'($urandom_range(255, ffrf_pkg::NUM_SLOTS + 1));
      return ffrf_pkg::LEN_W'($urandom_range(255));
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic send_item(ffrf_pkg::op_type op, logic [ffrf_pkg::SLOT_W-1:0] slot,
                            logic occ, logic [ffrf_pkg::LEN_W-1:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {len, occ, slot};
      do @(posedge clock); while (!req_tready);
      if (op == ffrf_pkg::OP_UPDATE) begin
         if (slot < ffrf_pkg::NUM_SLOTS) slot_map[slot] = occ;
         update_count++;
      end else begin
         pending_runs.push_back(find_first_free_run(len));
         search_count++;
      end
   endtask

   task automatic send_search(logic [ffrf_pkg::LEN_W-1:0] len);
      send_item(ffrf_pkg::OP_SEARCH, ffrf_pkg::SLOT_W'($urandom_range(127)),
                1'($urandom_range(1)), len);
   endtask

   task automatic send_update(int slot, logic occ);
      send_item(ffrf_pkg::OP_UPDATE, ffrf_pkg::SLOT_W'(slot), occ,
                ffrf_pkg::LEN_W'($urandom_range(255)));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_runs.size() != 0) @(posedge clock);
   endtask

   // rsp side
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      free_run_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_runs.size() == 0) begin
            report_mismatch("unexpected item, found", rsp_tuser, 0);
         end else begin
            want = pending_runs.pop_front();
            if (rsp_tuser !== want.found) begin
               report_mismatch("found", rsp_tuser, want.found);
            end
            if (rsp_tdata[ffrf_pkg::START_W-1:0] !== want.start_index) begin
               report_mismatch("start_index", rsp_tdata[ffrf_pkg::START_W-1:0],
                               want.start_index);
            end
            if (want.found) found_count++;
            else miss_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_special_cases();
      send_search(8'd1);
      send_search(ffrf_pkg::LEN_W'(ffrf_pkg::NUM_SLOTS));
      send_search(8'd0);
      send_search(ffrf_pkg::LEN_W'(ffrf_pkg::NUM_SLOTS + 1));
      send_search(8'd255);
      send_update(0, 1'b1);
      send_update(ffrf_pkg::NUM_SLOTS - 1, 1'b1);
      send_search(ffrf_pkg::LEN_W'(ffrf_pkg::NUM_SLOTS - 2));
      send_search(ffrf_pkg::LEN_W'(ffrf_pkg::NUM_SLOTS - 1));
      send_search(8'd1);
      send_update(64, 1'b1);
      send_search(8'd63);
      send_search(8'd64);
      send_search(8'd62);
      send_update(0, 1'b0);
      send_search(8'd64);
      send_search(8'd65);
      send_update(64, 1'b0);
      send_update(ffrf_pkg::NUM_SLOTS - 1, 1'b0);
      send_search(ffrf_pkg::LEN_W'(ffrf_pkg::NUM_SLOTS));
   endtask

   // walk the map full from the bottom, then empty from the top
   task automatic test_fill_and_drain();
      for (int s = 0; s < ffrf_pkg::NUM_SLOTS; s++) begin
         send_update(s, 1'b1);
         if (s % 8 == 7) send_search(random_run_length());
      end
      send_search(8'd1);
      send_update(ffrf_pkg::NUM_SLOTS - 1, 1'b0);
      send_search(8'd1);
      send_search(8'd2);
      for (int s = ffrf_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
         send_update(s, 1'b0);
         if (s % 8 == 0) send_search(random_run_length());
      end
   endtask

   task automatic test_random_traffic(int n_items, int sender_idle, int receiver_stall);
      int done;
      int density;
      int pick;
      done = 0;
      send_idle_pct = sender_idle;
      recv_stall_pct = receiver_stall;
      while (done < n_items) begin
         pick = $urandom_range(4);
         density = (pick == 0) ? 5 : (pick == 1) ? 25 : (pick == 2) ? 50 :
                   (pick == 3) ? 80 : 97;
         for (int k = 0; k < 40 && done < n_items; k++) begin
            if ($urandom_range(99) < 55) begin
               send_update($urandom_range(ffrf_pkg::NUM_SLOTS - 1),
                           ($urandom_range(99) < density));
            end else begin
               send_search(random_run_length());
            end
            done++;
         end
      end
   endtask

   initial begin
      send_idle_pct = 14;
      recv_stall_pct = 79;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_special_cases();
      wait_for_results();
      test_fill_and_drain();
      wait_for_results();
      test_random_traffic(380, 14, 79);
      wait_for_results();
      test_random_traffic(380, 79, 14);
      wait_for_results();
      test_random_traffic(380, 0, 0);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_runs.size() != 0) begin
         report_mismatch("items still outstanding", 0, pending_runs.size());
      end
      $display("covered %0d slot writes and %0d run searches (%0d hits, %0d misses)",
               update_count, search_count, found_count, miss_count);
      $display("map density swept from empty to full under three flow-control mixes");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
